// ===== hdl/slr_pkg.sv =====
// Shared constants, types and helpers for the quaternion slerp pipeline.
`timescale 1ns / 1ps
package slr_pkg;

  // Series and search sizes
  localparam int TERM_COUNT = 8;
  localparam int ACOS_BITS  = 31;
  localparam int DIV_BITS   = 31;

  // Fixed-point constants, Q2.30 unless noted
  localparam logic [30:0] ONE_Q30     = 31'd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] SMALL_Q30   = 31'd107374;
  localparam logic signed [33:0] DOT_ONE = 34'sd268435456;
  localparam logic [14:0] U_ONE       = 15'd16384;
  localparam logic signed [49:0] Q14_MAX = 50'sd16384;
  localparam logic signed [49:0] Q14_MIN = -50'sd16384;

  // Pipeline depths
  localparam int TAYLOR_LAT = 1 + 3 * TERM_COUNT;
  localparam int ACOS_LAT   = TAYLOR_LAT + 1;
  localparam int PIPE_LAT   = 2 + ACOS_BITS * ACOS_LAT + 1 + TAYLOR_LAT + DIV_BITS + 1;

  // Divisor of series term k: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic int term_div(bit is_sin, int k);
    return is_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
  endfunction

  // One result beat
  typedef struct packed {
    logic [3:0][15:0] blend;
    logic [14:0]      arc;
    logic             flipped;
  } slr_result_t;

endpackage

// ===== hdl/slr_term_cell.sv =====
// One series term cell: multiply by x^2, scale, divide by a constant, accumulate.
`timescale 1ns / 1ps
module slr_term_cell import slr_pkg::*; #(
  parameter int DIV    = 2,
  parameter bit NEG    = 1'b1,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [30:0]              term_in,
  input  logic [31:0]              x2_in,
  input  logic signed [33:0]       sum_in,
  input  logic [SIDE_W-1:0]        side_in,
  output logic [30:0]              term_out,
  output logic [31:0]              x2_out,
  output logic signed [33:0]       sum_out,
  output logic [SIDE_W-1:0]        side_out
);

  localparam logic [31:0] MAGIC = 32'((64'd1 << 32) / DIV);
  localparam logic [31:0] DIV_V = 32'(DIV);

  logic [62:0]              prod;
  logic [31:0]              a_n;
  logic [31:0]              a_x2;
  logic signed [33:0]       a_sum;
  logic [SIDE_W-1:0]        a_side;
  logic [63:0]              mprod;
  logic [31:0]              b_qa;
  logic [31:0]              b_n;
  logic [31:0]              b_x2;
  logic signed [33:0]       b_sum;
  logic [SIDE_W-1:0]        b_side;
  logic [31:0]              rem_c;
  logic [31:0]              q_c;
  logic signed [33:0]       q_s;

  // Stage A: term times x^2, back to Q2.30
  assign prod = 63'(term_in) * 63'(x2_in);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_n    <= prod[61:30];
      a_x2   <= x2_in;
      a_sum  <= sum_in;
      a_side <= side_in;
    end
  end

  // Stage B: estimate quotient with the reciprocal
  assign mprod = 64'(a_n) * 64'(MAGIC);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_qa   <= mprod[63:32];
      b_n    <= a_n;
      b_x2   <= a_x2;
      b_sum  <= a_sum;
      b_side <= a_side;
    end
  end

  // Stage C: correct the estimate by one and accumulate
  assign rem_c = b_n - b_qa * DIV_V;
  assign q_c   = b_qa + 32'(rem_c >= DIV_V);
  assign q_s   = $signed({3'b000, q_c[30:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      term_out <= q_c[30:0];
      x2_out   <= b_x2;
      sum_out  <= NEG ? b_sum - q_s : b_sum + q_s;
      side_out <= b_side;
    end
  end

endmodule

// ===== hdl/slr_taylor.sv =====
// Pipelined Taylor series for sine or cosine in Q2.30, as a chain of term cells.
`timescale 1ns / 1ps
module slr_taylor import slr_pkg::*; #(
  parameter bit IS_SIN = 1'b1,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [30:0]          x,
  input  logic [SIDE_W-1:0]    side_in,
  output logic signed [33:0]   sum_out,
  output logic [SIDE_W-1:0]    side_out
);

  logic [61:0]              sq;
  logic [30:0]              term0;
  logic [30:0]              term_c [TERM_COUNT+1];
  logic [31:0]              x2_c   [TERM_COUNT+1];
  logic signed [33:0]       sum_c  [TERM_COUNT+1];
  logic [SIDE_W-1:0]        side_c [TERM_COUNT+1];

  // Square the argument and seed the series
  assign sq    = 62'(x) * 62'(x);
  assign term0 = IS_SIN ? x : ONE_Q30;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2_c[0]   <= sq[61:30];
      term_c[0] <= term0;
      sum_c[0]  <= $signed({3'b000, term0});
      side_c[0] <= side_in;
    end
  end

  // Alternate signs down the chain
  for (genvar k = 1; k <= TERM_COUNT; k++) begin : g_term
    slr_term_cell #(
      .DIV    (term_div(IS_SIN, k)),
      .NEG    ((k % 2) == 1),
      .SIDE_W (SIDE_W)
    ) u_term (
      .clk      (clk),
      .adv      (adv),
      .term_in  (term_c[k-1]),
      .x2_in    (x2_c[k-1]),
      .sum_in   (sum_c[k-1]),
      .side_in  (side_c[k-1]),
      .term_out (term_c[k]),
      .x2_out   (x2_c[k]),
      .sum_out  (sum_c[k]),
      .side_out (side_c[k])
    );
  end

  assign sum_out  = sum_c[TERM_COUNT];
  assign side_out = side_c[TERM_COUNT];

endmodule

// ===== hdl/slr_acos_cell.sv =====
// One bisection cell of the arccosine: try one bit, keep it while cos stays above target.
`timescale 1ns / 1ps
module slr_acos_cell import slr_pkg::*; #(
  parameter int BIT    = 30,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [30:0]          theta_in,
  input  logic [30:0]          c_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic [30:0]          theta_out,
  output logic [30:0]          c_out,
  output logic [SIDE_W-1:0]    side_out
);

  localparam logic [30:0] STEP = 31'd1 << BIT;
  localparam int TW = SIDE_W + 93;

  logic [30:0]          cand;
  logic signed [33:0]   cos_sum;
  logic [TW-1:0]        t_side;
  logic [30:0]          t_theta;
  logic [30:0]          t_cand;
  logic [30:0]          t_c;
  logic [SIDE_W-1:0]    t_rest;
  logic                 keep;

  assign cand = theta_in | STEP;

  // Cosine of the candidate angle
  slr_taylor #(
    .IS_SIN (1'b0),
    .SIDE_W (TW)
  ) u_cos (
    .clk      (clk),
    .adv      (adv),
    .x        (cand),
    .side_in  ({theta_in, cand, c_in, side_in}),
    .sum_out  (cos_sum),
    .side_out (t_side)
  );

  assign {t_theta, t_cand, t_c, t_rest} = t_side;

  // Keep the bit while the angle stays in range and cos is still above target
  assign keep = (t_cand <= HALF_PI_Q30) && (cos_sum > $signed({3'b000, t_c}));

  always_ff @(posedge clk) begin
    if (adv) begin
      theta_out <= keep ? t_cand : t_theta;
      c_out     <= t_c;
      side_out  <= t_rest;
    end
  end

endmodule

// ===== hdl/slr_div_cell.sv =====
// One restoring-division cell: one quotient bit for each of two numerators.
`timescale 1ns / 1ps
module slr_div_cell import slr_pkg::*; #(
  parameter bit SHIFT  = 1'b1,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [30:0]          den_in,
  input  logic [31:0]          rem0_in,
  input  logic [31:0]          rem1_in,
  input  logic [30:0]          q0_in,
  input  logic [30:0]          q1_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic [30:0]          den_out,
  output logic [31:0]          rem0_out,
  output logic [31:0]          rem1_out,
  output logic [30:0]          q0_out,
  output logic [30:0]          q1_out,
  output logic [SIDE_W-1:0]    side_out
);

  logic [32:0] t0;
  logic [32:0] t1;
  logic [32:0] den_x;
  logic        ge0;
  logic        ge1;

  // Bring down the next zero bit when SHIFT is set, then trial-subtract
  assign t0    = SHIFT ? {rem0_in, 1'b0} : {1'b0, rem0_in};
  assign t1    = SHIFT ? {rem1_in, 1'b0} : {1'b0, rem1_in};
  assign den_x = {2'b00, den_in};
  assign ge0   = t0 >= den_x;
  assign ge1   = t1 >= den_x;

  always_ff @(posedge clk) begin
    if (adv) begin
      den_out  <= den_in;
      rem0_out <= ge0 ? 32'(t0 - den_x) : t0[31:0];
      rem1_out <= ge1 ? 32'(t1 - den_x) : t1[31:0];
      q0_out   <= {q0_in[29:0], ge0};
      q1_out   <= {q1_in[29:0], ge1};
      side_out <= side_in;
    end
  end

endmodule

// ===== hdl/quaternion_slerp_unit.sv =====
// Throughput: one beat per cycle unless the skid register is full; the depth is set by
//   the 31-cell arccosine chain, each cell a 25-stage cosine series plus a select
//   register, then the 25-stage sine series and a 31-cell divider.
// An output skid register takes one result while the output is stalled; input stall
//   rises only when that skid register is full.
// Reset clears the valid chain, the output valid and the skid flag; payload is not reset.
`timescale 1ns / 1ps
module quaternion_slerp_unit import slr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] first_c0,
  input  logic signed [15:0] first_c1,
  input  logic signed [15:0] first_c2,
  input  logic signed [15:0] first_c3,
  input  logic signed [15:0] second_c0,
  input  logic signed [15:0] second_c1,
  input  logic signed [15:0] second_c2,
  input  logic signed [15:0] second_c3,
  input  logic [14:0]        fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] blend_c0,
  output logic signed [15:0] blend_c1,
  output logic signed [15:0] blend_c2,
  output logic signed [15:0] blend_c3,
  output logic [14:0]        arc_distance,
  output logic               flipped
);

  localparam int ACOS_SIDE = 1 + 1 + 15 + 64 + 68;
  localparam int DIV_SIDE  = 64 + 68 + 15 + 1 + 31 + 1;

  logic adv;
  logic [PIPE_LAT-1:0] vld;

  // Stage 1 signals
  logic [3:0][15:0]   in_a;
  logic [3:0][15:0]   in_b;
  logic [14:0]        u_cl;
  logic signed [31:0] s1_prod [4];
  logic [3:0][15:0]   s1_a;
  logic [3:0][15:0]   s1_b;
  logic               s1_eq;
  logic [14:0]        s1_u;

  // Stage 2 signals
  logic signed [33:0] dot;
  logic signed [33:0] dot_cl;
  logic signed [33:0] mag;
  logic               flip2;
  logic [3:0][16:0]   bneg2;
  logic [30:0]        s2_c;
  logic               s2_eq;
  logic               s2_flip;
  logic [14:0]        s2_u;
  logic [3:0][15:0]   s2_a;
  logic [3:0][16:0]   s2_b;

  // Arccosine chain
  logic [30:0]          th_ch   [ACOS_BITS+1];
  logic [30:0]          c_ch    [ACOS_BITS+1];
  logic [ACOS_SIDE-1:0] side_ch [ACOS_BITS+1];
  logic                 ac_eq;
  logic                 ac_flip;
  logic [14:0]          ac_u;
  logic [3:0][15:0]     ac_a;
  logic [3:0][16:0]     ac_b;

  // Stage 3 signals
  logic [30:0]        theta3;
  logic [14:0]        um3;
  logic [45:0]        arg0_p;
  logic [45:0]        arg1_p;
  logic [30:0]        s3_theta;
  logic [30:0]        s3_arg0;
  logic [30:0]        s3_arg1;
  logic               s3_small;
  logic               s3_flip;
  logic [14:0]        s3_u;
  logic [3:0][15:0]   s3_a;
  logic [3:0][16:0]   s3_b;

  // Sine outputs
  logic signed [33:0] st_sum;
  logic signed [33:0] s0_sum;
  logic signed [33:0] s1_sum;
  logic [131:0]       st_side;
  logic [46:0]        s0_side;
  logic               s1_side;

  // Divider chain
  logic [30:0]         den_ch  [DIV_BITS+1];
  logic [31:0]         r0_ch   [DIV_BITS+1];
  logic [31:0]         r1_ch   [DIV_BITS+1];
  logic [30:0]         q0_ch   [DIV_BITS+1];
  logic [30:0]         q1_ch   [DIV_BITS+1];
  logic [DIV_SIDE-1:0] dside_ch [DIV_BITS+1];
  logic [3:0][15:0]    dv_a;
  logic [3:0][16:0]    dv_b;
  logic [14:0]         dv_u;
  logic                dv_flip;
  logic [30:0]         dv_theta;
  logic                dv_small;

  // Stage 5 signals
  logic [31:0]        wa;
  logic [31:0]        wb;
  logic signed [48:0] s5_pa [4];
  logic signed [48:0] s5_pb [4];
  logic               s5_small;
  logic [30:0]        s5_theta;
  logic               s5_flip;

  // Result and output stage
  slr_result_t        res;
  slr_result_t        out_r;
  slr_result_t        skid_r;
  logic               skid_full;
  logic               x_valid;
  logic [31:0]        arc_sum;

  // Advance the whole pipeline unless the skid register is holding a beat
  assign adv      = !skid_full;
  assign in_stall = skid_full;

  // Track valid beats through the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  // Stage 1: component products, equality, fraction clamp
  assign in_a = {first_c3, first_c2, first_c1, first_c0};
  assign in_b = {second_c3, second_c2, second_c1, second_c0};
  assign u_cl = (fraction > U_ONE) ? U_ONE : fraction;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s1_prod[i] <= 32'($signed(in_a[i])) * 32'($signed(in_b[i]));
      end
      s1_a  <= in_a;
      s1_b  <= in_b;
      s1_eq <= (in_a == in_b);
      s1_u  <= u_cl;
    end
  end

  // Stage 2: dot product, clamp, flip, arccosine target
  assign dot = 34'(s1_prod[0]) + 34'(s1_prod[1]) + 34'(s1_prod[2]) + 34'(s1_prod[3]);
  assign dot_cl = (dot > DOT_ONE) ? DOT_ONE : ((dot < -DOT_ONE) ? -DOT_ONE : dot);
  assign flip2  = dot_cl < 0;
  assign mag    = flip2 ? -dot_cl : dot_cl;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      bneg2[i] = flip2 ? 17'(-17'($signed(s1_b[i]))) : 17'($signed(s1_b[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c    <= {mag[28:0], 2'b00};
      s2_eq   <= s1_eq;
      s2_flip <= flip2;
      s2_u    <= s1_u;
      s2_a    <= s1_a;
      s2_b    <= bneg2;
    end
  end

  // Arccosine by bisection, most significant bit first
  assign th_ch[0]   = '0;
  assign c_ch[0]    = s2_c;
  assign side_ch[0] = {s2_eq, s2_flip, s2_u, s2_a, s2_b};

  for (genvar j = 0; j < ACOS_BITS; j++) begin : g_acos
    slr_acos_cell #(
      .BIT    (ACOS_BITS - 1 - j),
      .SIDE_W (ACOS_SIDE)
    ) u_cell (
      .clk       (clk),
      .adv       (adv),
      .theta_in  (th_ch[j]),
      .c_in      (c_ch[j]),
      .side_in   (side_ch[j]),
      .theta_out (th_ch[j+1]),
      .c_out     (c_ch[j+1]),
      .side_out  (side_ch[j+1])
    );
  end

  assign {ac_eq, ac_flip, ac_u, ac_a, ac_b} = side_ch[ACOS_BITS];

  // Stage 3: final angle, small-angle test, sine arguments
  assign theta3 = ac_eq ? '0 : th_ch[ACOS_BITS];
  assign um3    = U_ONE - ac_u;
  assign arg0_p = 46'(um3) * 46'(theta3);
  assign arg1_p = 46'(ac_u) * 46'(theta3);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_theta <= theta3;
      s3_arg0  <= arg0_p[44:14];
      s3_arg1  <= arg1_p[44:14];
      s3_small <= theta3 <= SMALL_Q30;
      s3_flip  <= ac_flip;
      s3_u     <= ac_u;
      s3_a     <= ac_a;
      s3_b     <= ac_b;
    end
  end

  // Three sines in parallel
  slr_taylor #(.IS_SIN(1'b1), .SIDE_W(132)) u_sin_t (
    .clk      (clk),
    .adv      (adv),
    .x        (s3_theta),
    .side_in  ({s3_a, s3_b}),
    .sum_out  (st_sum),
    .side_out (st_side)
  );

  slr_taylor #(.IS_SIN(1'b1), .SIDE_W(47)) u_sin_0 (
    .clk      (clk),
    .adv      (adv),
    .x        (s3_arg0),
    .side_in  ({s3_u, s3_flip, s3_theta}),
    .sum_out  (s0_sum),
    .side_out (s0_side)
  );

  slr_taylor #(.IS_SIN(1'b1), .SIDE_W(1)) u_sin_1 (
    .clk      (clk),
    .adv      (adv),
    .x        (s3_arg1),
    .side_in  (s3_small),
    .sum_out  (s1_sum),
    .side_out (s1_side)
  );

  // Weights: sin(arg) / sin(theta) in Q2.30, negative sines clamped to zero
  assign den_ch[0]   = st_sum[30:0];
  assign r0_ch[0]    = (s0_sum < 0) ? '0 : {1'b0, s0_sum[30:0]};
  assign r1_ch[0]    = (s1_sum < 0) ? '0 : {1'b0, s1_sum[30:0]};
  assign q0_ch[0]    = '0;
  assign q1_ch[0]    = '0;
  assign dside_ch[0] = {st_side, s0_side, s1_side};

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    slr_div_cell #(
      .SHIFT  (j != 0),
      .SIDE_W (DIV_SIDE)
    ) u_div (
      .clk      (clk),
      .adv      (adv),
      .den_in   (den_ch[j]),
      .rem0_in  (r0_ch[j]),
      .rem1_in  (r1_ch[j]),
      .q0_in    (q0_ch[j]),
      .q1_in    (q1_ch[j]),
      .side_in  (dside_ch[j]),
      .den_out  (den_ch[j+1]),
      .rem0_out (r0_ch[j+1]),
      .rem1_out (r1_ch[j+1]),
      .q0_out   (q0_ch[j+1]),
      .q1_out   (q1_ch[j+1]),
      .side_out (dside_ch[j+1])
    );
  end

  assign {dv_a, dv_b, dv_u, dv_flip, dv_theta, dv_small} = dside_ch[DIV_BITS];

  // Stage 5: weighted components, linear weights for small angles
  assign wa = dv_small ? {17'b0, 15'(U_ONE - dv_u)} : {1'b0, q0_ch[DIV_BITS]};
  assign wb = dv_small ? {17'b0, dv_u} : {1'b0, q1_ch[DIV_BITS]};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        s5_pa[i] <= 49'($signed({1'b0, wa})) * 49'($signed(dv_a[i]));
        s5_pb[i] <= 49'($signed({1'b0, wb})) * 49'($signed(dv_b[i]));
      end
      s5_small <= dv_small;
      s5_theta <= dv_theta;
      s5_flip  <= dv_flip;
    end
  end

  // Round half up, saturate, and form the distance
  assign arc_sum = 32'(s5_theta) + 32'd32768;

  always_comb begin
    logic signed [49:0] v;
    logic signed [49:0] r;
    res.arc     = arc_sum[30:16];
    res.flipped = s5_flip;
    for (int i = 0; i < 4; i++) begin
      v = 50'(s5_pa[i]) + 50'(s5_pb[i]);
      r = s5_small ? ((v + 50'sd8192) >>> 14) : ((v + 50'sd536870912) >>> 30);
      if (r > Q14_MAX) begin
        r = Q14_MAX;
      end else if (r < Q14_MIN) begin
        r = Q14_MIN;
      end
      res.blend[i] = r[15:0];
    end
  end

  assign x_valid = vld[PIPE_LAT-1];

  // Output register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!skid_full) begin
      if (out_valid && out_stall) begin
        if (x_valid) begin
          skid_full <= 1'b1;
        end
      end else begin
        out_valid <= x_valid;
      end
    end else if (!out_stall) begin
      skid_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      if (out_valid && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end else if (!out_stall) begin
      out_r <= skid_r;
    end
  end

  assign blend_c0     = out_r.blend[0];
  assign blend_c1     = out_r.blend[1];
  assign blend_c2     = out_r.blend[2];
  assign blend_c3     = out_r.blend[3];
  assign arc_distance = out_r.arc;
  assign flipped      = out_r.flipped;

  // The skid register only holds a beat behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid register full without a valid output beat");

  // The skid register fills only when the output was stalled
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid register filled while output was free");

  // Distance never exceeds pi/2 in Q1.14
  a_arc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> arc_distance <= 15'd25736)
    else $error("arc distance out of range");

  // Blend components 0 and 3 stay saturated to the Q2.14 unit range
  a_blend_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(blend_c0) <= 16'sd16384 && $signed(blend_c0) >= -16'sd16384
                && $signed(blend_c3) <= 16'sd16384 && $signed(blend_c3) >= -16'sd16384))
    else $error("blend component out of range");

endmodule

// ===== tb/quaternion_slerp_unit_tb.sv =====
// Self-checking testbench for quaternion_slerp_unit: directed table, random stream, predictor.
`timescale 1ns / 1ps
module quaternion_slerp_unit_tb;
  import slr_pkg::*;

  typedef struct packed {
    logic [3:0][15:0] first;
    logic [3:0][15:0] second;
    logic [14:0]      frac;
  } slerp_req_t;

  typedef struct {
    slerp_req_t  req;
    bit          known;
    slr_result_t want;
  } dir_row_t;

  localparam int EXP_DEPTH = 2048;
  localparam int DIR_DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] first_c0 = '0, first_c1 = '0, first_c2 = '0, first_c3 = '0;
  logic signed [15:0] second_c0 = '0, second_c1 = '0, second_c2 = '0, second_c3 = '0;
  logic [14:0] fraction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] blend_c0, blend_c1, blend_c2, blend_c3;
  logic [14:0] arc_distance;
  logic flipped;

  slr_result_t exp_fifo [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  dir_row_t    dir_rows [DIR_DEPTH];
  int          dir_count = 0;
  int          err_count = 0;
  int          beats_out = 0;
  bit          send_done = 1'b0;
  int          item_idx = 0;

  quaternion_slerp_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .first_c0(first_c0), .first_c1(first_c1), .first_c2(first_c2), .first_c3(first_c3),
    .second_c0(second_c0), .second_c1(second_c1), .second_c2(second_c2),
    .second_c3(second_c3), .fraction(fraction),
    .out_valid(out_valid), .out_stall(out_stall),
    .blend_c0(blend_c0), .blend_c1(blend_c1), .blend_c2(blend_c2), .blend_c3(blend_c3),
    .arc_distance(arc_distance), .flipped(flipped)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Taylor sine, Q2.30
  function automatic longint series_sin(longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= TERM_COUNT; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2) sum -= longint'(term); else sum += longint'(term);
    end
    return sum;
  endfunction

  // Taylor cosine, Q2.30
  function automatic longint series_cos(longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = longint'(term);
    for (int k = 1; k <= TERM_COUNT; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2) sum -= longint'(term); else sum += longint'(term);
    end
    return sum;
  endfunction

  // Bit-serial arccosine search over bits 30..0
  function automatic longint unsigned arc_search(longint c);
    longint unsigned theta, cand;
    theta = 0;
    for (int bit_i = 30; bit_i >= 0; bit_i--) begin
      cand = theta + (64'd1 << bit_i);
      if (cand <= longint'(HALF_PI_Q30) && series_cos(cand) > c) theta = cand;
    end
    return theta;
  endfunction

  function automatic logic [15:0] clip_q14(longint v);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  // Expected slerp result for one request
  function automatic slr_result_t slerp_predict(slerp_req_t r);
    longint a[4], b[4], dotp, mag, st, s0, s1, w0, w1, acc;
    longint unsigned theta, u;
    bit same, flip;
    slr_result_t res;
    dotp = 0;
    same = 1'b1;
    flip = 1'b0;
    theta = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(r.first[i]));
      b[i] = longint'($signed(r.second[i]));
      if (a[i] != b[i]) same = 1'b0;
      dotp += a[i] * b[i];
    end
    u = r.frac;
    if (u > 16384) u = 16384;
    if (!same) begin
      if (dotp > 64'sd268435456) dotp = 64'sd268435456;
      if (dotp < -64'sd268435456) dotp = -64'sd268435456;
      flip = dotp < 0;
      mag = flip ? -dotp : dotp;
      theta = arc_search(mag * 4);
    end
    if (flip) for (int i = 0; i < 4; i++) b[i] = -b[i];
    if (theta > longint'(SMALL_Q30)) begin
      st = series_sin(theta);
      s0 = series_sin(((16384 - u) * theta) >> 14);
      s1 = series_sin((u * theta) >> 14);
      if (s0 < 0) s0 = 0;
      if (s1 < 0) s1 = 0;
      w0 = longint'((longint'(s0) << 30) / st);
      w1 = longint'((longint'(s1) << 30) / st);
      for (int i = 0; i < 4; i++) begin
        acc = w0 * a[i] + w1 * b[i];
        res.blend[i] = clip_q14((acc + (64'sd1 <<< 29)) >>> 30);
      end
    end else begin
      w0 = 16384 - longint'(u);
      w1 = longint'(u);
      for (int i = 0; i < 4; i++) begin
        acc = w0 * a[i] + w1 * b[i];
        res.blend[i] = clip_q14((acc + 64'sd8192) >>> 14);
      end
    end
    res.arc = 15'((theta + 32768) >> 16);
    res.flipped = flip;
    return res;
  endfunction

  task automatic add_row(input int a0, a1, a2, a3, b0, b1, b2, b3, uu,
                         input bit known, input int e0, e1, e2, e3, earc, input bit eflip);
    dir_row_t row;
    row.req.first  = {16'(a3), 16'(a2), 16'(a1), 16'(a0)};
    row.req.second = {16'(b3), 16'(b2), 16'(b1), 16'(b0)};
    row.req.frac   = 15'(uu);
    row.known      = known;
    row.want.blend = {16'(e3), 16'(e2), 16'(e1), 16'(e0)};
    row.want.arc   = 15'(earc);
    row.want.flipped = eflip;
    dir_rows[dir_count] = row;
    dir_count++;
  endtask

  // Unit quaternion in Q2.14, normalized from four real components
  function automatic logic [3:0][15:0] unit_quat(real p0, real p1, real p2, real p3);
    real n;
    logic [3:0][15:0] q;
    n = $sqrt(p0 * p0 + p1 * p1 + p2 * p2 + p3 * p3);
    if (n < 1.0e-9) begin
      p0 = 1.0;
      n = 1.0;
    end
    q[0] = 16'($rtoi(p0 / n * 16384.0));
    q[1] = 16'($rtoi(p1 / n * 16384.0));
    q[2] = 16'($rtoi(p2 / n * 16384.0));
    q[3] = 16'($rtoi(p3 / n * 16384.0));
    return q;
  endfunction

  function automatic real rnd_sym();
    return (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
  endfunction

  function automatic slerp_req_t random_req();
    slerp_req_t r;
    int kind;
    real d;
    kind = $urandom_range(0, 99);
    r.first = unit_quat(rnd_sym(), rnd_sym(), rnd_sym(), rnd_sym());
    if (kind < 40) begin
      r.second = unit_quat(rnd_sym(), rnd_sym(), rnd_sym(), rnd_sym());
    end else if (kind < 75) begin
      // nearby rotation, either sign, spread over several scales
      d = 1.0 / real'(1 << $urandom_range(1, 14));
      r.second = unit_quat($itor($signed(r.first[0])) / 16384.0 + d * rnd_sym(),
                           $itor($signed(r.first[1])) / 16384.0 + d * rnd_sym(),
                           $itor($signed(r.first[2])) / 16384.0 + d * rnd_sym(),
                           $itor($signed(r.first[3])) / 16384.0 + d * rnd_sym());
      if ($urandom_range(0, 1))
        for (int i = 0; i < 4; i++) r.second[i] = -$signed(r.second[i]);
    end else if (kind < 85) begin
      r.second = r.first;
    end else begin
      r.first  = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      r.second = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    end
    r.frac = ($urandom_range(0, 9) == 0) ? 15'($urandom) : 15'($urandom_range(0, 16384));
    return r;
  endfunction

  // Drive one beat and hold it until accepted; log its expectation
  task automatic send_beat(input slerp_req_t r, input bit known, input slr_result_t want);
    int gap;
    gap = (item_idx >= 400 && item_idx < 550) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {first_c3, first_c2, first_c1, first_c0}     = r.first;
    {second_c3, second_c2, second_c1, second_c0} = r.second;
    fraction = r.frac;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    exp_fifo[exp_wr] = known ? want : slerp_predict(r);
    exp_wr++;
    item_idx++;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    slr_result_t none;
    none = '0;
    // equal inputs give the first quaternion back at zero distance
    add_row(16384, 0, 0, 0, 16384, 0, 0, 0, 8192, 1, 16384, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 16384, 0, 0, 0, 16384, 16384, 1, 0, 0, 0, 16384, 0, 0);
    // opposite quaternions: flip, zero arc, linear blend
    add_row(16384, 0, 0, 0, -16384, 0, 0, 0, 4096, 1, 16384, 0, 0, 0, 0, 1);
    // fraction extremes and over-range fraction
    add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0);
    add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 32767, 0, 0, 0, 0, 0, 0, 0);
    add_row(16384, 0, 0, 0, 0, 16384, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);
    // negative dot product
    add_row(11585, 11585, 0, 0, -16384, 0, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);
    add_row(8192, 8192, 8192, 8192, -8192, 8192, -8192, -8192, 12000, 0, 0, 0, 0, 0, 0, 0);
    // small angle, just below and above threshold
    add_row(16384, 0, 0, 0, 16384, 1, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);
    add_row(16384, 0, 0, 0, 16383, 3, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);
    add_row(16384, 0, 0, 0, 16380, 200, 0, 0, 5000, 0, 0, 0, 0, 0, 0, 0);
    // out-of-range components: clamp and saturate
    add_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 16384,
            1, 16384, 16384, 16384, 16384, 0, 0);
    add_row(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0,
            1, -16384, -16384, -16384, -16384, 0, 0);
    add_row(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 8192,
            0, 0, 0, 0, 0, 0, 0);
    add_row(32767, 0, 0, 0, 0, -32768, 0, 0, 3000, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 8192, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 16384, 0, 0, 0, 8192, 0, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < dir_count; i++)
      send_beat(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
    repeat (1100) send_beat(random_req(), 1'b0, none);
    in_valid = 1'b0;
    send_done = 1'b1;
  end

  // Output side: check each beat, draw the next hold-off
  initial begin
    int hold;
    slr_result_t got, want;
    bit held_long;
    hold = 0;
    held_long = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.blend = {blend_c3, blend_c2, blend_c1, blend_c0};
        got.arc = arc_distance;
        got.flipped = flipped;
        if (exp_rd == exp_wr) begin
          err_count++;
          $display("%0t: unexpected result beat, expected none, got blend=%h arc=%0d flipped=%0b",
                   $time, got.blend, got.arc, got.flipped);
        end else begin
          want = exp_fifo[exp_rd];
          exp_rd++;
          for (int i = 0; i < 4; i++)
            if (got.blend[i] !== want.blend[i]) begin
              err_count++;
              $display("%0t: blend_c%0d expected %0d got %0d", $time, i,
                       $signed(want.blend[i]), $signed(got.blend[i]));
            end
          if (got.arc !== want.arc) begin
            err_count++;
            $display("%0t: arc_distance expected %0d got %0d", $time, want.arc, got.arc);
          end
          if (got.flipped !== want.flipped) begin
            err_count++;
            $display("%0t: flipped expected %0b got %0b", $time, want.flipped, got.flipped);
          end
        end
        beats_out++;
        if (beats_out == 150 && !held_long) begin
          // long hold-off so the pipeline fills and stalls its input
          hold = 2000;
          held_long = 1'b1;
        end else if (beats_out >= 380 && beats_out < 560) begin
          hold = 0;
        end else begin
          hold = $urandom_range(0, 6);
        end
      end
      @(negedge clk);
      out_stall = (hold > 0);
      if (hold > 0) hold--;
    end
  end

  // End of run
  initial begin
    wait (send_done);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (900) @(posedge clk);
    if (err_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Timeout
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
